// File: rtl/ham_pkg.sv
// shared types and constants of the hopfield associative memory
`timescale 1ns / 1ps
package ham_pkg;

  localparam int NeuronsDef     = 128;
  localparam int MaxPatternsDef = 15;
  localparam int WordBitsDef    = 32;

  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 8;
  localparam int WeightW   = 5;

  localparam logic [CfgIdxW-1:0] CfgPatternLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxSweeps     = 1'b1;

  localparam logic [WeightW-1:0] WeightMax = 5'sd15;
  localparam logic [WeightW-1:0] WeightMin = 5'b10000;

  localparam logic [7:0] LenReset    = 8'd100;
  localparam logic [7:0] SweepsReset = 8'd32;

  typedef enum logic [1:0] {
    OP_TRAIN  = 2'd0,
    OP_RECALL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_NOCONV   = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_TRAIN  = 2'd0,
    CMD_RECALL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_WORD = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLR,
    BK_TRD,
    BK_TWR,
    BK_RSTART,
    BK_RACC,
    BK_RLAST,
    BK_RUPD,
    BK_EMIT,
    BK_ACK
  } bk_state_e;

  typedef struct packed {
    logic push;
    cmd_e cmd;
  } cmd_req_t;

  typedef struct packed {
    logic idle;
    logic q_empty;
  } bk_status_t;

endpackage

// File: rtl/ham_in_if.sv
// input channel of the hopfield associative memory
`timescale 1ns / 1ps
interface ham_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       bit_value;
  logic       last_bit;

  modport source (output valid, output operation, output bit_value, output last_bit,
                  input ready);
  modport sink (input valid, input operation, input bit_value, input last_bit,
                output ready);
endinterface

// File: rtl/ham_out_if.sv
// result channel of the hopfield associative memory
`timescale 1ns / 1ps
interface ham_out_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [1:0]           status;
  logic [WORD_BITS-1:0] word_bits;
  logic [1:0]           word_index;
  logic [7:0]           sweeps_used;
  logic                 last_word;

  modport source (output valid, output kind, output status, output word_bits,
                  output word_index, output sweeps_used, output last_word, input ready);
  modport sink (input valid, input kind, input status, input word_bits,
                input word_index, input sweeps_used, input last_word, output ready);
endinterface

// File: rtl/hopfield_associative_memory_top.sv
// top level of the hopfield associative memory
`timescale 1ns / 1ps
// Bipolar Hopfield associative memory with Hebbian training. Words come in one
// neuron bit each; the word with last_bit set starts a train or recall run, and a
// clear word starts a clear at once. A train run sweeps the used length squared
// weights, each a read then a write of the weight memory, and returns one
// acknowledgement. A recall run reads one weight a cycle in each sweep and then
// emits its words. Clear, and reset, run a clearing pass over all NEURONS*NEURONS
// weights, one per cycle, during which no word is taken. Bit words are taken while
// the back end is idle and the command queue is empty; the result register lets the
// next run start while a result still waits.
module hopfield_associative_memory_top #(
  parameter int NEURONS      = ham_pkg::NeuronsDef,
  parameter int MAX_PATTERNS = ham_pkg::MaxPatternsDef,
  parameter int WORD_BITS    = ham_pkg::WordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ham_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ham_pkg::CfgDataW-1:0]  cfg_data_i,
  ham_in_if.sink                        in_i,
  ham_out_if.source                     out_o
);
  import ham_pkg::*;

  localparam int LW = $clog2(NEURONS + 1);

  logic [7:0]         plen_q, sweeps_q;
  logic [LW-1:0]      len;
  cmd_req_t           req;
  cmd_e               cmd;
  logic               q_empty, q_full, pop;
  bk_status_t         bk_st;
  logic [NEURONS-1:0] pattern, probe;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= LenReset;
      sweeps_q <= SweepsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatternLength: plen_q   <= cfg_data_i;
        CfgMaxSweeps:     sweeps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // used length clamped to one .. NEURONS
  always_comb begin
    if (plen_q == 8'd0) len = LW'(1);
    else if (int'(plen_q) > NEURONS) len = LW'(NEURONS);
    else len = LW'(plen_q);
  end

  ham_front #(.NEURONS(NEURONS), .LW(LW)) u_front (
    .clk_i, .rst_ni, .in_i, .len_i(len), .bk_i(bk_st), .req_o(req),
    .pattern_o(pattern), .probe_o(probe)
  );

  // command queue; q_full never stops the front, which waits for an empty queue
  ham_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .req_i(req), .pop_i(pop), .cmd_o(cmd),
    .empty_o(q_empty), .full_o(q_full)
  );

  ham_back #(.NEURONS(NEURONS), .MAX_PATTERNS(MAX_PATTERNS), .WORD_BITS(WORD_BITS),
             .LW(LW)) u_back (
    .clk_i, .rst_ni, .len_i(len), .limit_i(sweeps_q), .cmd_i(cmd),
    .q_empty_i(q_empty), .pop_o(pop), .status_o(bk_st),
    .pattern_i(pattern), .probe_i(probe), .out_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !req.push)
    else $error("command pushed into a full queue");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (bk_st.idle && q_empty))
    else $error("input taken while back end busy");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");
endmodule

// File: rtl/ham_cmd_fifo.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
module ham_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ham_pkg::cmd_req_t req_i,
  input  logic              pop_i,
  output ham_pkg::cmd_e     cmd_o,
  output logic              empty_o,
  output logic              full_o
);
  import ham_pkg::*;

  cmd_e       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = req_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= req_i.cmd;
    end
  end
endmodule

// File: rtl/ham_front.sv
// front end: takes pattern and probe bits, queues train, recall and clear commands
`timescale 1ns / 1ps
module ham_front #(
  parameter int NEURONS = ham_pkg::NeuronsDef,
  parameter int LW      = $clog2(NEURONS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ham_in_if.sink               in_i,
  input  logic [LW-1:0]        len_i,
  input  ham_pkg::bk_status_t  bk_i,
  output ham_pkg::cmd_req_t    req_o,
  output logic [NEURONS-1:0]   pattern_o,
  output logic [NEURONS-1:0]   probe_o
);
  import ham_pkg::*;

  localparam int IW = $clog2(NEURONS);

  logic [LW-1:0]      pos_q, pos_d;
  logic [NEURONS-1:0] pattern_q, probe_q;
  logic               acc;
  op_e                op;

  assign in_i.ready = bk_i.idle && bk_i.q_empty;
  assign acc        = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.operation);
  assign pattern_o  = pattern_q;
  assign probe_o    = probe_q;

  always_comb begin
    pos_d     = pos_q;
    req_o     = '{push: 1'b0, cmd: CMD_TRAIN};
    if (acc) begin
      unique case (op)
        OP_CLEAR: begin
          pos_d = '0;
          req_o = '{push: 1'b1, cmd: CMD_CLEAR};
        end
        OP_TRAIN, OP_RECALL: begin
          if (pos_q < len_i) pos_d = pos_q + 1'b1;
          if (in_i.last_bit) begin
            pos_d = '0;
            req_o = '{push: 1'b1, cmd: (op == OP_TRAIN) ? CMD_TRAIN : CMD_RECALL};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // bit buffers, written at the running position
  always_ff @(posedge clk_i) begin
    if (acc && (pos_q < len_i)) begin
      if (op == OP_TRAIN) pattern_q[pos_q[IW-1:0]] <= in_i.bit_value;
      if (op == OP_RECALL) probe_q[pos_q[IW-1:0]] <= in_i.bit_value;
    end
  end
endmodule

// File: rtl/ham_back.sv
// back end: weight memory, hebbian training, sweep recall and result register
`timescale 1ns / 1ps
module ham_back #(
  parameter int NEURONS      = ham_pkg::NeuronsDef,
  parameter int MAX_PATTERNS = ham_pkg::MaxPatternsDef,
  parameter int WORD_BITS    = ham_pkg::WordBitsDef,
  parameter int LW           = $clog2(NEURONS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LW-1:0]       len_i,
  input  logic [7:0]          limit_i,
  input  ham_pkg::cmd_e       cmd_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output ham_pkg::bk_status_t status_o,
  input  logic [NEURONS-1:0]  pattern_i,
  input  logic [NEURONS-1:0]  probe_i,
  ham_out_if.source           out_o
);
  import ham_pkg::*;

  localparam int IW    = $clog2(NEURONS);
  localparam int DEPTH = NEURONS * NEURONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_PATTERNS + 2);
  localparam int NETW  = $clog2(NEURONS * 16 + 2) + 1;
  localparam int NWORD = (NEURONS + WORD_BITS - 1) / WORD_BITS;
  localparam int KW    = (NWORD > 1) ? $clog2(NWORD) : 1;
  localparam int BW    = $clog2(NEURONS + WORD_BITS + 1);

  bk_state_e state_q, state_d;

  logic [WeightW-1:0] mem [DEPTH];
  logic [WeightW-1:0] rdata_q;
  logic [AW-1:0]      raddr, waddr;
  logic               mem_we;
  logic [WeightW-1:0] wdata;

  logic [IW-1:0]      i_q, i_d, j_q, j_d, rj_q;
  logic [AW-1:0]      ca_q, ca_d;
  logic               rv_q;
  logic               ack_q, ack_d;
  logic               flag_q, flag_d;
  logic [SW-1:0]      stored_q, stored_d;
  logic [NEURONS-1:0] ns_q, ns_d;
  logic signed [NETW-1:0] net_q, net_d;
  logic [7:0]         sweeps_q, sweeps_d;
  logic               chg_q, chg_d;
  logic [KW-1:0]      k_q, k_d;
  logic [7:0]         limit;
  logic               i_last, j_last, pi, pj, w_sat;
  logic signed [WeightW-1:0] w_old;
  logic [WORD_BITS-1:0] word;
  logic               word_last;

  logic               ov_q, ov_d, okind_q, okind_d, olast_q, olast_d;
  logic [1:0]         ost_q, ost_d, oidx_q, oidx_d;
  logic [WORD_BITS-1:0] obits_q, obits_d;
  logic [7:0]         osw_q, osw_d;
  logic               out_free;

  assign limit    = (limit_i == 8'd0) ? 8'd1 : limit_i;
  assign i_last   = (LW'(i_q) + 1'b1) == len_i;
  assign j_last   = (LW'(j_q) + 1'b1) == len_i;
  assign pi       = pattern_i[i_q];
  assign pj       = pattern_i[j_q];
  assign w_old    = rdata_q;
  assign out_free = !ov_q || out_o.ready;

  assign status_o = '{idle: (state_q == BK_IDLE), q_empty: q_empty_i};

  // packed word k, bits past the used length read as zero
  always_comb begin
    logic [BW-1:0] n;
    word = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      n = BW'(k_q) * BW'(WORD_BITS) + BW'(b);
      if (n < BW'(len_i)) word[b] = ns_q[n[IW-1:0]];
    end
    word_last = (BW'(k_q) + 1'b1) * BW'(WORD_BITS) >= BW'(len_i);
  end

  // saturation when the product pushes past either rail
  assign w_sat = (pi == pj) ? (w_old == WeightMax) : (w_old == WeightMin);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    ca_d     = ca_q;
    ack_d    = ack_q;
    flag_d   = flag_q;
    stored_d = stored_q;
    ns_d     = ns_q;
    net_d    = net_q;
    sweeps_d = sweeps_q;
    chg_d    = chg_q;
    k_d      = k_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    waddr    = AW'(i_q) * AW'(NEURONS) + AW'(j_q);
    wdata    = '0;
    raddr    = AW'(i_q) * AW'(NEURONS) + AW'(j_q);
    ov_d     = ov_q && !out_o.ready;
    okind_d  = okind_q;
    olast_d  = olast_q;
    ost_d    = ost_q;
    oidx_d   = oidx_q;
    obits_d  = obits_q;
    osw_d    = osw_q;

    if (rv_q && (rj_q != i_q)) begin
      net_d = ns_q[rj_q] ? net_q + NETW'(signed'(rdata_q))
                         : net_q - NETW'(signed'(rdata_q));
    end

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          i_d   = '0;
          j_d   = '0;
          unique case (cmd_i)
            CMD_CLEAR: begin
              ca_d     = '0;
              ack_d    = 1'b1;
              stored_d = '0;
              state_d  = BK_CLR;
            end
            CMD_TRAIN: begin
              flag_d  = 1'b0;
              state_d = BK_TRD;
            end
            CMD_RECALL: begin
              ns_d     = probe_i;
              sweeps_d = '0;
              state_d  = BK_RSTART;
            end
            default: ;
          endcase
        end
      end
      BK_CLR: begin
        mem_we = 1'b1;
        waddr  = ca_q;
        ca_d   = ca_q + 1'b1;
        if (ca_q == AW'(DEPTH - 1)) begin
          flag_d  = 1'b0;
          state_d = ack_q ? BK_ACK : BK_IDLE;
        end
      end
      BK_TRD: state_d = BK_TWR;
      BK_TWR: begin
        mem_we = 1'b1;
        if (i_q == j_q) begin
          wdata = '0;
        end else if (w_sat) begin
          wdata  = w_old;
          flag_d = 1'b1;
        end else begin
          wdata = (pi == pj) ? w_old + 1'b1 : w_old - 1'b1;
        end
        state_d = BK_TRD;
        j_d     = j_q + 1'b1;
        if (j_last) begin
          j_d = '0;
          i_d = i_q + 1'b1;
          if (i_last) begin
            if (stored_q <= SW'(MAX_PATTERNS)) stored_d = stored_q + 1'b1;
            if (stored_d > SW'(MAX_PATTERNS)) flag_d = 1'b1;
            state_d = BK_ACK;
          end
        end
      end
      BK_RSTART: begin
        sweeps_d = sweeps_q + 1'b1;
        chg_d    = 1'b0;
        i_d      = '0;
        j_d      = '0;
        net_d    = probe_i[0] ? NETW'(1) : -NETW'(1);
        state_d  = BK_RACC;
      end
      BK_RACC: begin
        raddr = AW'(j_q) * AW'(NEURONS) + AW'(i_q);
        j_d   = j_q + 1'b1;
        if (j_last) state_d = BK_RLAST;
      end
      BK_RLAST: state_d = BK_RUPD;
      BK_RUPD: begin
        if (net_q > 0 && !ns_q[i_q]) begin
          ns_d[i_q] = 1'b1;
          chg_d     = 1'b1;
        end else if (net_q < 0 && ns_q[i_q]) begin
          ns_d[i_q] = 1'b0;
          chg_d     = 1'b1;
        end
        if (i_last) begin
          k_d     = '0;
          state_d = (chg_d && sweeps_q < limit) ? BK_RSTART : BK_EMIT;
        end else begin
          i_d     = i_q + 1'b1;
          j_d     = '0;
          net_d   = probe_i[i_d] ? NETW'(1) : -NETW'(1);
          state_d = BK_RACC;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_WORD;
          ost_d   = chg_q ? ST_NOCONV : ST_OK;
          obits_d = word;
          oidx_d  = 2'(k_q);
          osw_d   = sweeps_q;
          olast_d = word_last;
          k_d     = k_q + 1'b1;
          if (word_last) state_d = BK_IDLE;
        end
      end
      BK_ACK: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_ACK;
          ost_d   = flag_q ? ST_SAT : ST_OK;
          obits_d = '0;
          oidx_d  = '0;
          osw_d   = '0;
          olast_d = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_CLR;
      ca_q     <= '0;
      ack_q    <= 1'b0;
      stored_q <= '0;
      rv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ca_q     <= ca_d;
      ack_q    <= ack_d;
      stored_q <= stored_d;
      rv_q     <= (state_q == BK_RACC);
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    rj_q     <= j_q;
    flag_q   <= flag_d;
    ns_q     <= ns_d;
    net_q    <= net_d;
    sweeps_q <= sweeps_d;
    chg_q    <= chg_d;
    k_q      <= k_d;
    okind_q  <= okind_d;
    ost_q    <= ost_d;
    obits_q  <= obits_d;
    oidx_q   <= oidx_d;
    osw_q    <= osw_d;
    olast_q  <= olast_d;
  end

  // weight memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign out_o.valid       = ov_q;
  assign out_o.kind        = okind_q;
  assign out_o.status      = ost_q;
  assign out_o.word_bits   = obits_q;
  assign out_o.word_index  = oidx_q;
  assign out_o.sweeps_used = osw_q;
  assign out_o.last_word   = olast_q;

  a_rv_from_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(state_q == BK_RACC))
    else $error("read valid without a recall issue cycle");

  a_upd_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUPD) |-> $past(state_q == BK_RLAST))
    else $error("neuron update before its sum is complete");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == BK_TWR || state_q == BK_CLR))
    else $error("weight write outside train or clear");

  a_idle_no_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE && ov_q && !out_o.ready) |=> ov_q)
    else $error("pending result dropped");
endmodule

// File: tb/tb_hopfield_associative_memory_top.sv
// testbench of the hopfield associative memory: directed and random runs checked by a predictor
`timescale 1ns / 1ps
module tb_hopfield_associative_memory_top;
  import ham_pkg::*;

  localparam int N = NeuronsDef;

  // one result word as the block presents it
  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [31:0] bits;
    logic [1:0] idx;
    logic [7:0] sweeps;
    logic       last;
  } res_word_t;

  // one row of the directed table; acks with an obvious value are typed in
  typedef struct {
    op_e op;
    bit  val;
    bit  lst;
    bit  typed;
  } plan_row_t;

  localparam res_word_t AckOk = '{1'b0, ST_OK, 32'd0, 2'd0, 8'd0, 1'b1};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  ham_in_if                    in_if ();
  ham_out_if #(.WORD_BITS(32)) out_if ();

  hopfield_associative_memory_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor state: weights, bit buffers, and which positions were ever written
  logic signed [4:0] wmem [N][N];
  bit          pat [N];
  bit          prb [N];
  bit          nst [N];
  bit          pat_set [N];
  bit          prb_set [N];
  bit          recent_pat [N];
  int          pos;
  int          stored;
  logic [7:0]  len_reg;
  logic [7:0]  sweep_reg;

  res_word_t   words_due [$];
  plan_row_t   plan [$];
  int          errors;
  int          burst_left;
  int          stall_cnt;
  int          stall_mode;

  // clock, 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard limit on the run, far above the slowest correct run
  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // used neuron count, clamped to 1..N
  function automatic int used_len();
    int n;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > N) n = N;
    return n;
  endfunction

  // queue one predicted result word
  function automatic void expect_word(res_word_t w);
    words_due = {words_due, w};
  endfunction

  // advance the predictor by one accepted word; queue results when keep is set
  task automatic memory_step(op_e op, bit val, bit lst, bit keep);
    int len, i, j, v, lim, sw, nw, k, net;
    bit flag, chg;
    res_word_t w;
    len = used_len();
    if (op == OP_NONE) return;
    if (op == OP_CLEAR) begin
      for (i = 0; i < N; i++)
        for (j = 0; j < N; j++) wmem[i][j] = '0;
      stored = 0;
      pos = 0;
      if (keep) expect_word(AckOk);
      return;
    end
    if (pos < len) begin
      if (op == OP_TRAIN) begin
        pat[pos] = val;
        pat_set[pos] = 1'b1;
      end else begin
        prb[pos] = val;
        prb_set[pos] = 1'b1;
      end
      pos++;
    end
    if (!lst) return;
    pos = 0;
    if (op == OP_TRAIN) begin
      // hebbian outer product with saturation, diagonal held at zero
      flag = 1'b0;
      for (i = 0; i < len; i++)
        for (j = 0; j < len; j++) begin
          if (i == j) begin
            wmem[i][j] = '0;
          end else begin
            v = int'(wmem[i][j]) + ((pat[i] == pat[j]) ? 1 : -1);
            if (v > 15) begin v = 15; flag = 1'b1; end
            if (v < -16) begin v = -16; flag = 1'b1; end
            wmem[i][j] = v[4:0];
          end
        end
      if (stored <= MaxPatternsDef) stored++;
      if (stored > MaxPatternsDef) flag = 1'b1;
      w = AckOk;
      w.status = flag ? ST_SAT : ST_OK;
      if (keep) expect_word(w);
      return;
    end
    // recall: sequential sweeps in ascending neuron order
    lim = (sweep_reg == 0) ? 1 : int'(sweep_reg);
    for (i = 0; i < len; i++) nst[i] = prb[i];
    sw = 0;
    chg = 1'b1;
    while (chg && sw < lim) begin
      chg = 1'b0;
      sw++;
      for (i = 0; i < len; i++) begin
        net = prb[i] ? 1 : -1;
        for (j = 0; j < len; j++)
          if (j != i) net += nst[j] ? int'(wmem[j][i]) : -int'(wmem[j][i]);
        if (net > 0 && !nst[i]) begin nst[i] = 1'b1; chg = 1'b1; end
        else if (net < 0 && nst[i]) begin nst[i] = 1'b0; chg = 1'b1; end
      end
    end
    nw = (len + 31) / 32;
    for (k = 0; k < nw; k++) begin
      w.kind = 1'b1;
      w.status = chg ? ST_NOCONV : ST_OK;
      w.bits = '0;
      for (i = 0; i < 32; i++)
        if (k * 32 + i < len) w.bits[i] = nst[k * 32 + i];
      w.idx = k[1:0];
      w.sweeps = sw[7:0];
      w.last = (k + 1 == nw);
      if (keep) expect_word(w);
    end
  endtask

  // drive one word in bursts with random gaps; starts and ends at a falling edge
  task automatic send(op_e op, bit val, bit lst, bit keep);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.bit_value <= val;
    in_if.last_bit  <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    memory_step(op, val, lst, keep);
    burst_left--;
    @(negedge clk_i);
  endtask

  // sender pauses until every result is back, then lets the back end settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (words_due.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgPatternLength) len_reg = data;
    else sweep_reg = data;
    @(negedge clk_i);
  endtask

  task automatic add_row(op_e op, bit val, bit lst, bit typed);
    plan_row_t r;
    r.op = op;
    r.val = val;
    r.lst = lst;
    r.typed = typed;
    plan = {plan, r};
  endtask

  // one random run: mostly well formed patterns and noisy probes, some broken ones
  task automatic random_run();
    int len, n, i, p, r;
    op_e fin, other;
    op_e ops [$];
    bit vals [$];
    bit ok, have;
    len = used_len();
    r = $urandom_range(0, 99);
    if (r < 7) begin
      send(OP_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    fin = (r < 55) ? OP_TRAIN : OP_RECALL;
    other = (fin == OP_TRAIN) ? OP_RECALL : OP_TRAIN;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len + 3) : len;
    have = ($urandom_range(0, 2) != 0);
    for (i = 0; i < n; i++) begin
      ops = {ops, (($urandom_range(0, 9) == 0) ? other : fin)};
      if (fin == OP_RECALL && i < N)
        // probe near the latest stored pattern, a bit flipped now and then
        vals = {vals, bit'(recent_pat[i] ^ ($urandom_range(0, 5) == 0))};
      else if (have && i < N)
        vals = {vals, recent_pat[i]};
      else
        vals = {vals, 1'($urandom_range(0, 1))};
    end
    // never read a buffer position that was not written since reset
    ok = 1'b1;
    for (p = 0; p < len; p++)
      if (!((fin == OP_TRAIN) ? pat_set[p] : prb_set[p]) && !(p < n && ops[p] == fin))
        ok = 1'b0;
    if (!ok) begin
      for (i = 0; i < n; i++) ops[i] = fin;
      while (n < len) begin
        ops = {ops, fin};
        vals = {vals, 1'($urandom_range(0, 1))};
        n++;
      end
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send(OP_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      send(ops[i], vals[i], i == n - 1, 1'b1);
    end
    if (fin == OP_TRAIN)
      for (i = 0; i < n && i < N; i++) recent_pat[i] = vals[i];
  endtask

  // receiver stalls on a pattern of its own, switching style every so often
  always @(negedge clk_i) begin
    stall_cnt++;
    if (stall_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_if.ready <= ($urandom_range(0, 9) == 0);
      end
      default: begin
        out_if.ready <= (stall_cnt % 8 < 5);
      end
    endcase
  end

  // result checker: each accepted word against the oldest prediction
  always @(posedge clk_i) begin
    res_word_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        e = words_due.pop_front();
        if (out_if.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_if.kind);
          errors++;
        end
        if (out_if.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_if.status);
          errors++;
        end
        if (out_if.word_bits !== e.bits) begin
          $error("word_bits: expected %h, got %h", e.bits, out_if.word_bits);
          errors++;
        end
        if (out_if.word_index !== e.idx) begin
          $error("word_index: expected %0d, got %0d", e.idx, out_if.word_index);
          errors++;
        end
        if (out_if.sweeps_used !== e.sweeps) begin
          $error("sweeps_used: expected %0d, got %0d", e.sweeps, out_if.sweeps_used);
          errors++;
        end
        if (out_if.last_word !== e.last) begin
          $error("last_word: expected %0d, got %0d", e.last, out_if.last_word);
          errors++;
        end
      end
    end
  end

  initial begin
    int ph, i, guard;
    int ph_len [7];
    int ph_sw [7];
    int ph_runs [7];
    // phases: extremes and odd sizes; the full size only briefly
    ph_len  = '{32, 4, 0, 16, 255, 9, 5};
    ph_sw   = '{32, 1, 3, 255, 2, 5, 0};
    ph_runs = '{1, 6, 3, 2, 1, 2, 4};
    errors = 0;
    burst_left = 0;
    stall_cnt = 0;
    stall_mode = 0;
    pos = 0;
    stored = 0;
    len_reg = LenReset;
    sweep_reg = SweepsReset;
    for (i = 0; i < N; i++) begin
      pat_set[i] = 1'b0;
      prb_set[i] = 1'b0;
      recent_pat[i] = 1'b0;
    end
    for (i = 0; i < N; i++)
      for (guard = 0; guard < N; guard++) wmem[i][guard] = '0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.operation = OP_NONE;
    in_if.bit_value = 1'b0;
    in_if.last_bit = 1'b0;
    out_if.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at four neurons and a zero sweep limit (acts as one)
    cfg_write(CfgPatternLength, 8'd4);
    cfg_write(CfgMaxSweeps, 8'd0);
    add_row(OP_CLEAR, 1'b0, 1'b0, 1'b1);
    add_row(OP_NONE, 1'b1, 1'b1, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b0, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b1, 1'b1);
    add_row(OP_RECALL, 1'b1, 1'b0, 1'b0);
    add_row(OP_RECALL, 1'b0, 1'b0, 1'b0);
    add_row(OP_RECALL, 1'b0, 1'b0, 1'b0);
    add_row(OP_RECALL, 1'b1, 1'b1, 1'b0);
    // too many bits: the extra ones are dropped
    add_row(OP_TRAIN, 1'b0, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b0, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b0, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b1, 1'b1);
    // short probe keeps the older tail
    add_row(OP_RECALL, 1'b1, 1'b0, 1'b0);
    add_row(OP_RECALL, 1'b1, 1'b1, 1'b0);
    // mixed run, final word decides it is a recall
    add_row(OP_TRAIN, 1'b1, 1'b0, 1'b0);
    add_row(OP_RECALL, 1'b0, 1'b0, 1'b0);
    add_row(OP_TRAIN, 1'b1, 1'b0, 1'b0);
    add_row(OP_RECALL, 1'b1, 1'b1, 1'b0);
    add_row(OP_CLEAR, 1'b1, 1'b1, 1'b1);
    add_row(OP_NONE, 1'b0, 1'b0, 1'b0);
    for (i = 0; i < plan.size(); i++) begin
      send(plan[i].op, plan[i].val, plan[i].lst, !plan[i].typed);
      if (plan[i].typed) expect_word(AckOk);
    end

    // random phases, each set up while the block is idle
    for (ph = 0; ph < 7; ph++) begin
      drain();
      cfg_write(CfgPatternLength, ph_len[ph][7:0]);
      cfg_write(CfgMaxSweeps, ph_sw[ph][7:0]);
      for (i = 0; i < ph_runs[ph]; i++) random_run();
    end

    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
